>>> sv/bia_pkg.sv
// Shared types and constants for the bitmap ID allocator.
package bia_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int ID_W      = 10;
  localparam int POOL_W    = 11;
  localparam int STATUS_W  = 3;
  localparam int POOL_RST  = 1024;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [0:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_t;

endpackage

>>> sv/bia_in_if.sv
// Request channel interface: valid/ready plus the request fields.
interface bia_in_if;
  logic                        valid;
  logic                        ready;
  bia_pkg::mode_t              mode;
  logic [bia_pkg::ID_W-1:0]    id_to_free;

  modport source (output valid, output mode, output id_to_free, input ready);
  modport sink   (input valid, input mode, input id_to_free, output ready);
endinterface

>>> sv/bia_out_if.sv
// Result channel interface: valid/ready plus the result fields.
interface bia_out_if;
  logic                        valid;
  logic                        ready;
  bia_pkg::status_t            status;
  logic [bia_pkg::ID_W-1:0]    granted_id;

  modport source (output valid, output status, output granted_id, input ready);
  modport sink   (input valid, input status, input granted_id, output ready);
endinterface

>>> sv/bia_map_ram.sv
// Free-map word memory: one write port, one registered read port.
module bia_map_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  bia_pkg::word_t      wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output bia_pkg::word_t      rdata
);

  bia_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bia_ffs.sv
// Lowest-set-bit finder over one free-map word.
module bia_ffs (
  input  bia_pkg::word_t              data,
  output logic [bia_pkg::BIT_W-1:0]   idx,
  output logic                        any
);

  bia_pkg::word_t lowest;

  // Isolate the lowest set bit, then encode the one-hot result.
  assign lowest = data & (~data + bia_pkg::word_t'(1));
  assign any    = |data;

  always_comb begin
    logic acc;
    for (int k = 0; k < bia_pkg::BIT_W; k++) begin
      acc = 1'b0;
      for (int j = 0; j < bia_pkg::WORD_BITS; j++) begin
        if (((j >> k) & 1) == 1) begin
          acc = acc | lowest[j];
        end
      end
      idx[k] = acc;
    end
  end

endmodule

>>> sv/bia_seq.sv
// Allocator sequencer: map rebuild sweep, word scan, grant and free.
module bia_seq #(
  parameter int MAX_IDS   = 1024,
  parameter int NUM_WORDS = 16,
  parameter int WIDX_W    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bia_pkg::POOL_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bia_pkg::mode_t                 in_mode,
  input  logic [bia_pkg::ID_W-1:0]       in_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bia_pkg::status_t               out_status,
  output logic [bia_pkg::ID_W-1:0]       out_id,
  output logic                           ram_we,
  output logic [WIDX_W-1:0]              ram_waddr,
  output bia_pkg::word_t                 ram_wdata,
  output logic [WIDX_W-1:0]              ram_raddr,
  input  bia_pkg::word_t                 ram_rdata,
  input  logic [bia_pkg::BIT_W-1:0]      ffs_idx,
  input  logic                           ffs_any
);

  localparam int WCNT_W   = $clog2(NUM_WORDS + 1);
  localparam int POOL_INI = (bia_pkg::POOL_RST > MAX_IDS) ? MAX_IDS : bia_pkg::POOL_RST;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_GRANT,
    S_FREE_RD,
    S_FREE_CHK
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bia_pkg::POOL_W-1:0]      pool_r, pool_nxt;
  logic [WIDX_W-1:0]               clr_w_r, clr_w_nxt;
  logic [WCNT_W-1:0]               scan_w_r, scan_w_nxt;
  logic                            pend_r, pend_nxt;
  logic [WIDX_W-1:0]               chk_w_r, chk_w_nxt;
  logic [WIDX_W-1:0]               hit_w_r, hit_w_nxt;
  logic [bia_pkg::BIT_W-1:0]       hit_b_r, hit_b_nxt;
  bia_pkg::word_t                  hit_d_r, hit_d_nxt;
  logic [WIDX_W-1:0]               fid_w_r, fid_w_nxt;
  logic [bia_pkg::BIT_W-1:0]       fid_b_r, fid_b_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bia_pkg::status_t                out_status_r, out_status_nxt;
  logic [bia_pkg::ID_W-1:0]        out_id_r, out_id_nxt;

  bia_pkg::word_t                  fill_word;
  logic [WIDX_W+bia_pkg::BIT_W-1:0] cand;

  assign in_ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign cand       = {hit_w_r, hit_b_r};

  // Rebuild pattern for the word under the sweep pointer.
  always_comb begin
    if (32'(clr_w_r) < 32'(pool_r[bia_pkg::POOL_W-1:bia_pkg::BIT_W])) begin
      fill_word = '1;
    end else if (32'(clr_w_r) == 32'(pool_r[bia_pkg::POOL_W-1:bia_pkg::BIT_W])) begin
      fill_word = ~(bia_pkg::word_t'('1) << pool_r[bia_pkg::BIT_W-1:0]);
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pool_nxt       = pool_r;
    clr_w_nxt      = clr_w_r;
    scan_w_nxt     = scan_w_r;
    pend_nxt       = 1'b0;
    chk_w_nxt      = chk_w_r;
    hit_w_nxt      = hit_w_r;
    hit_b_nxt      = hit_b_r;
    hit_d_nxt      = hit_d_r;
    fid_w_nxt      = fid_w_r;
    fid_b_nxt      = fid_b_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_w_r;
        ram_wdata = fill_word;
        if (32'(clr_w_r) == NUM_WORDS - 1) begin
          clr_w_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_w_nxt = clr_w_r + WIDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_id_nxt = '0;
          if (pool_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bia_pkg::ST_EMPTY;
          end else if (in_mode == bia_pkg::MODE_ALLOC) begin
            scan_w_nxt = '0;
            state_nxt  = S_SCAN;
          end else if ((32'(in_id) >= 32'(pool_r)) ||
                       (32'(in_id[bia_pkg::ID_W-1:bia_pkg::BIT_W]) >= NUM_WORDS)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bia_pkg::ST_RANGE;
          end else begin
            fid_w_nxt = WIDX_W'(in_id[bia_pkg::ID_W-1:bia_pkg::BIT_W]);
            fid_b_nxt = in_id[bia_pkg::BIT_W-1:0];
            state_nxt = S_FREE_RD;
          end
        end
      end
      S_SCAN: begin
        // Issue one word read per cycle; check the word read last cycle.
        if (32'(scan_w_r) < NUM_WORDS) begin
          ram_raddr  = scan_w_r[WIDX_W-1:0];
          scan_w_nxt = scan_w_r + WCNT_W'(1);
          pend_nxt   = 1'b1;
          chk_w_nxt  = scan_w_r[WIDX_W-1:0];
        end
        if (pend_r) begin
          if (ffs_any) begin
            hit_d_nxt = ram_rdata;
            hit_b_nxt = ffs_idx;
            hit_w_nxt = chk_w_r;
            pend_nxt  = 1'b0;
            state_nxt = S_GRANT;
          end else if (32'(chk_w_r) == NUM_WORDS - 1) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bia_pkg::ST_NO_FREE;
            pend_nxt       = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_GRANT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (32'(cand) < 32'(pool_r)) begin
          ram_we         = 1'b1;
          ram_waddr      = hit_w_r;
          ram_wdata      = hit_d_r & ~(bia_pkg::word_t'(1) << hit_b_r);
          out_status_nxt = bia_pkg::ST_OK;
          out_id_nxt     = bia_pkg::ID_W'(cand);
        end else begin
          out_status_nxt = bia_pkg::ST_NO_FREE;
        end
      end
      S_FREE_RD: begin
        ram_raddr = fid_w_r;
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (ram_rdata[fid_b_r]) begin
          out_status_nxt = bia_pkg::ST_DOUBLE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = fid_w_r;
          ram_wdata      = ram_rdata | (bia_pkg::word_t'(1) << fid_b_r);
          out_status_nxt = bia_pkg::ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A size write saturates to capacity and restarts the rebuild sweep.
    if (cfg_wr_en) begin
      if (32'(cfg_wr_data) > MAX_IDS) begin
        pool_nxt = bia_pkg::POOL_W'(MAX_IDS);
      end else begin
        pool_nxt = cfg_wr_data;
      end
      clr_w_nxt = '0;
      pend_nxt  = 1'b0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pool_r      <= bia_pkg::POOL_W'(POOL_INI);
      clr_w_r     <= '0;
      scan_w_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      clr_w_r     <= clr_w_nxt;
      scan_w_r    <= scan_w_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r      <= chk_w_nxt;
    hit_w_r      <= hit_w_nxt;
    hit_b_r      <= hit_b_nxt;
    hit_d_r      <= hit_d_nxt;
    fid_w_r      <= fid_w_nxt;
    fid_b_r      <= fid_b_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

>>> sv/bitmap_id_allocator_top.sv
// Bitmap ID allocator: sequencer, free-map memory and lowest-set-bit finder.
// Allocate: the word scan makes one free-map memory read per cycle through the single read port,
//   then the grant writes the word back with the found bit cleared if it lies in the pool.
// Free: read, then check and write back. Errors found at transfer: result in the next cycle.
// One request at a time; the next transfer is taken the cycle after the result transfer.
// Reset (rst_n, synchronous) and each pool_size write: map sweep over all NUM_WORDS words, no transfer.
module bitmap_id_allocator_top #(
  parameter int MAX_IDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bia_pkg::POOL_W-1:0]    cfg_wr_data,
  bia_in_if.sink                        in_if,
  bia_out_if.source                     out_if
);

  // Map geometry: one 64-bit word per 64 IDs, rounded up.
  localparam int NUM_WORDS = (MAX_IDS + bia_pkg::WORD_BITS - 1) / bia_pkg::WORD_BITS;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // Memory port wiring between the sequencer and the free map.
  logic                         ram_we;
  logic [WIDX_W-1:0]            ram_waddr;
  bia_pkg::word_t               ram_wdata;
  logic [WIDX_W-1:0]            ram_raddr;
  bia_pkg::word_t               ram_rdata;

  // Lowest-set-bit result on the word just read.
  logic [bia_pkg::BIT_W-1:0]    ffs_idx;
  logic                         ffs_any;

  // Free map: bit b of word w is ID w*64+b, set means free.
  bia_map_ram #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (WIDX_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared finder: looks at every word the memory returns.
  bia_ffs u_ffs (
    .data (ram_rdata),
    .idx  (ffs_idx),
    .any  (ffs_any)
  );

  // Sequencer: hold the pool size, sweep the map on rebuild, scan on allocate,
  // read-modify-write on free, and drive the result register.
  bia_seq #(
    .MAX_IDS   (MAX_IDS),
    .NUM_WORDS (NUM_WORDS),
    .WIDX_W    (WIDX_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_mode     (in_if.mode),
    .in_id       (in_if.id_to_free),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_status  (out_if.status),
    .out_id      (out_if.granted_id),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ffs_idx     (ffs_idx),
    .ffs_any     (ffs_any)
  );

endmodule
